[rtl/spq_pkg.sv]
// types, codes and helpers shared by the stable priority queue modules
`default_nettype none
package spq_pkg;

  localparam int AGE_W  = 8;
  localparam int PRIO_W = 2;
  localparam int COND_W = 2;

  typedef enum logic [0:0] {
    OP_ADD  = 1'b0,
    OP_PROC = 1'b1
  } opcode_t;

  localparam logic [COND_W-1:0] COND_CRITICAL = 2'd0;
  localparam logic [COND_W-1:0] COND_URGENT   = 2'd1;

  localparam logic [PRIO_W-1:0] PRIO_NONE     = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_CRITICAL = 2'd1;
  localparam logic [PRIO_W-1:0] PRIO_URGENT   = 2'd2;
  localparam logic [PRIO_W-1:0] PRIO_NORMAL   = 2'd3;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } spq_state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
  } spq_cmd_t;

  function automatic logic [PRIO_W-1:0] prio_of(input logic [COND_W-1:0] code);
    logic [PRIO_W-1:0] p;
    case (code)
      COND_CRITICAL: p = PRIO_CRITICAL;
      COND_URGENT:   p = PRIO_URGENT;
      default:       p = PRIO_NORMAL;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

[rtl/spq_ctrl.sv]
// controller: accept / execute sequencing and output word valid
`default_nettype none
module spq_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  output spq_pkg::spq_cmd_t cmd
);
  import spq_pkg::*;

  spq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd.load_in = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_exec_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("executed item left no output word");
  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> (state_r == ST_EXEC))
    else $error("accepted item not taken to execute");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.exec)
    else $error("stalled output word overwritten");
`endif

endmodule
`default_nettype wire

[rtl/spq_dpath.sv]
// datapath: sorted shifting chain of slots, input latch and output word registers
`default_nettype none
module spq_dpath #(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire spq_pkg::spq_cmd_t          cmd,
  input  wire logic                       in_opcode,
  input  wire logic [TAG_BITS-1:0]        in_entry_tag,
  input  wire logic [spq_pkg::AGE_W-1:0]  in_entry_age,
  input  wire logic [spq_pkg::COND_W-1:0] in_condition_code,
  output logic                            out_popped_valid,
  output logic [TAG_BITS-1:0]             out_popped_tag,
  output logic [spq_pkg::AGE_W-1:0]       out_popped_age,
  output logic [spq_pkg::PRIO_W-1:0]      out_popped_priority,
  output logic                            out_empty_flag,
  output logic                            out_rejected_flag,
  output logic [$clog2(DEPTH + 1)-1:0]    out_entry_count,
  output logic                            out_front_valid,
  output logic [TAG_BITS-1:0]             out_front_tag
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  opcode_t           op_r;
  logic [TAG_BITS-1:0] tag_in_r;
  logic [AGE_W-1:0]  age_in_r;
  logic [PRIO_W-1:0] prio_in_r;

  logic [TAG_BITS-1:0] tag_r [DEPTH];
  logic [AGE_W-1:0]    age_r [DEPTH];
  logic [PRIO_W-1:0]   prio_r[DEPTH];
  logic [TAG_BITS-1:0] tag_nxt [DEPTH];
  logic [AGE_W-1:0]    age_nxt [DEPTH];
  logic [PRIO_W-1:0]   prio_nxt[DEPTH];

  logic [TAG_BITS-1:0] up_tag [DEPTH];
  logic [AGE_W-1:0]    up_age [DEPTH];
  logic [PRIO_W-1:0]   up_prio[DEPTH];
  logic [DEPTH-1:0]    up_ge;
  logic [TAG_BITS-1:0] dn_tag [DEPTH];
  logic [AGE_W-1:0]    dn_age [DEPTH];
  logic [PRIO_W-1:0]   dn_prio[DEPTH];

  logic [DEPTH-1:0] ge;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             full, empty, do_ins, do_pop;

  logic                popped_valid_nxt, empty_flag_nxt, rejected_flag_nxt, front_valid_nxt;
  logic [TAG_BITS-1:0] popped_tag_nxt, front_tag_nxt;
  logic [AGE_W-1:0]    popped_age_nxt;
  logic [PRIO_W-1:0]   popped_prio_nxt;

  assign full   = (fill_r == CNT_W'(DEPTH));
  assign empty  = (fill_r == '0);
  assign do_ins = cmd.exec && (op_r == OP_ADD) && !full;
  assign do_pop = cmd.exec && (op_r == OP_PROC) && !empty;

  // slots ahead of the insert point: stored and of equal or better priority
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (CNT_W'(i) < fill_r) && (prio_r[i] <= prio_in_r);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_link
    if (i == 0) begin : g_head
      assign up_tag[i]  = tag_in_r;
      assign up_age[i]  = age_in_r;
      assign up_prio[i] = prio_in_r;
      assign up_ge[i]   = 1'b1;
    end else begin : g_body
      assign up_tag[i]  = tag_r[i-1];
      assign up_age[i]  = age_r[i-1];
      assign up_prio[i] = prio_r[i-1];
      assign up_ge[i]   = ge[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign dn_tag[i]  = tag_r[i];
      assign dn_age[i]  = age_r[i];
      assign dn_prio[i] = prio_r[i];
    end else begin : g_mid
      assign dn_tag[i]  = tag_r[i+1];
      assign dn_age[i]  = age_r[i+1];
      assign dn_prio[i] = prio_r[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      tag_nxt[i]  = tag_r[i];
      age_nxt[i]  = age_r[i];
      prio_nxt[i] = prio_r[i];
      if (do_ins && !ge[i]) begin
        if (up_ge[i]) begin
          tag_nxt[i]  = tag_in_r;
          age_nxt[i]  = age_in_r;
          prio_nxt[i] = prio_in_r;
        end else begin
          tag_nxt[i]  = up_tag[i];
          age_nxt[i]  = up_age[i];
          prio_nxt[i] = up_prio[i];
        end
      end else if (do_pop) begin
        tag_nxt[i]  = dn_tag[i];
        age_nxt[i]  = dn_age[i];
        prio_nxt[i] = dn_prio[i];
      end
    end
  end

  always_comb begin
    fill_nxt          = fill_r;
    popped_valid_nxt  = 1'b0;
    popped_tag_nxt    = '0;
    popped_age_nxt    = '0;
    popped_prio_nxt   = PRIO_NONE;
    empty_flag_nxt    = 1'b0;
    rejected_flag_nxt = 1'b0;
    front_valid_nxt   = 1'b0;
    front_tag_nxt     = '0;
    if (op_r == OP_ADD) begin
      front_valid_nxt = 1'b1;
      if (full) begin
        rejected_flag_nxt = 1'b1;
        front_tag_nxt     = tag_r[0];
      end else begin
        fill_nxt      = fill_r + CNT_W'(1);
        front_tag_nxt = ge[0] ? tag_r[0] : tag_in_r;
      end
    end else if (empty) begin
      empty_flag_nxt = 1'b1;
    end else begin
      fill_nxt         = fill_r - CNT_W'(1);
      popped_valid_nxt = 1'b1;
      popped_tag_nxt   = tag_r[0];
      popped_age_nxt   = age_r[0];
      popped_prio_nxt  = prio_r[0];
      front_valid_nxt  = (fill_r > CNT_W'(1));
      front_tag_nxt    = (fill_r > CNT_W'(1)) ? tag_r[1] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r      <= opcode_t'(in_opcode);
      tag_in_r  <= in_entry_tag;
      age_in_r  <= in_entry_age;
      prio_in_r <= prio_of(in_condition_code);
    end
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        tag_r[i]  <= tag_nxt[i];
        age_r[i]  <= age_nxt[i];
        prio_r[i] <= prio_nxt[i];
      end
      out_popped_valid    <= popped_valid_nxt;
      out_popped_tag      <= popped_tag_nxt;
      out_popped_age      <= popped_age_nxt;
      out_popped_priority <= popped_prio_nxt;
      out_empty_flag      <= empty_flag_nxt;
      out_rejected_flag   <= rejected_flag_nxt;
      out_entry_count     <= fill_nxt;
      out_front_valid     <= front_valid_nxt;
      out_front_tag       <= front_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.exec) begin
      fill_r <= fill_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> (fill_r == $past(fill_r) + CNT_W'(1)))
    else $error("insert did not raise fill count");
  a_pop_prio: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> (out_popped_priority != PRIO_NONE) && out_popped_valid)
    else $error("popped word without a priority");
`endif

endmodule
`default_nettype wire

[rtl/stable_priority_queue_core.sv]
// top level of the stable priority queue: controller plus slot-chain datapath
// the result word is registered when the accepted item is executed, which waits while the output is stalled
// the controller's accept then execute sequence takes no new item until the accepted one has been executed
// an add inserts (unless full) and a process pops (unless empty) on the shifting slot chain
// reset (synchronous, active low) clears fill count and output valid; slots are not cleared
`default_nettype none
module stable_priority_queue_core #(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_opcode,
  input  wire logic [TAG_BITS-1:0]        in_entry_tag,
  input  wire logic [spq_pkg::AGE_W-1:0]  in_entry_age,
  input  wire logic [spq_pkg::COND_W-1:0] in_condition_code,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_popped_valid,
  output logic [TAG_BITS-1:0]             out_popped_tag,
  output logic [spq_pkg::AGE_W-1:0]       out_popped_age,
  output logic [spq_pkg::PRIO_W-1:0]      out_popped_priority,
  output logic                            out_empty_flag,
  output logic                            out_rejected_flag,
  output logic [$clog2(DEPTH + 1)-1:0]    out_entry_count,
  output logic                            out_front_valid,
  output logic [TAG_BITS-1:0]             out_front_tag
);
  import spq_pkg::*;

  spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  spq_dpath #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_opcode           (in_opcode),
    .in_entry_tag        (in_entry_tag),
    .in_entry_age        (in_entry_age),
    .in_condition_code   (in_condition_code),
    .out_popped_valid    (out_popped_valid),
    .out_popped_tag      (out_popped_tag),
    .out_popped_age      (out_popped_age),
    .out_popped_priority (out_popped_priority),
    .out_empty_flag      (out_empty_flag),
    .out_rejected_flag   (out_rejected_flag),
    .out_entry_count     (out_entry_count),
    .out_front_valid     (out_front_valid),
    .out_front_tag       (out_front_tag)
  );

endmodule
`default_nettype wire

[tb/spq_checker.sv]
// checker for the stable priority queue: tracks the queue, predicts each result word and compares
`default_nettype none
module spq_checker #(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16,
  parameter int CNT_W    = 5
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire logic                         in_opcode,
  input  wire logic [TAG_BITS-1:0]          in_entry_tag,
  input  wire logic [spq_pkg::AGE_W-1:0]    in_entry_age,
  input  wire logic [spq_pkg::COND_W-1:0]   in_condition_code,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  input  wire logic                         out_popped_valid,
  input  wire logic [TAG_BITS-1:0]          out_popped_tag,
  input  wire logic [spq_pkg::AGE_W-1:0]    out_popped_age,
  input  wire logic [spq_pkg::PRIO_W-1:0]   out_popped_priority,
  input  wire logic                         out_empty_flag,
  input  wire logic                         out_rejected_flag,
  input  wire logic [CNT_W-1:0]             out_entry_count,
  input  wire logic                         out_front_valid,
  input  wire logic [TAG_BITS-1:0]          out_front_tag,
  output int                                fail_count,
  output int                                pending,
  output int                                words_seen,
  output int                                pops_seen,
  output int                                empty_seen,
  output int                                rejects_seen,
  output int                                full_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  typedef struct {
    logic [TAG_BITS-1:0] tag;
    logic [AGE_W-1:0]    age;
    logic [PRIO_W-1:0]   prio;
  } ward_slot_t;

  typedef struct {
    logic                popped_valid;
    logic [TAG_BITS-1:0] popped_tag;
    logic [AGE_W-1:0]    popped_age;
    logic [PRIO_W-1:0]   popped_priority;
    logic                empty_flag;
    logic                rejected_flag;
    logic [CNT_W-1:0]    entry_count;
    logic                front_valid;
    logic [TAG_BITS-1:0] front_tag;
  } triage_word_t;

  ward_slot_t   ward [DEPTH];
  int unsigned  ward_fill;
  triage_word_t due_words [$];
  triage_word_t oldest;

  initial begin
    fail_count   = 0;
    pending      = 0;
    words_seen   = 0;
    pops_seen    = 0;
    empty_seen   = 0;
    rejects_seen = 0;
    full_seen    = 0;
    ward_fill    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch at word %0d: %s", $realtime, words_seen, msg);
    fail_count++;
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", field, got, want));
    end
  endtask

  task automatic triage_step(input opcode_t op, input logic [TAG_BITS-1:0] tag,
                             input logic [AGE_W-1:0] age, input logic [COND_W-1:0] cond);
    triage_word_t      w;
    logic [PRIO_W-1:0] level;
    int unsigned       pos;
    int unsigned       i;
    w = '{default: '0};
    if (op == OP_ADD) begin
      if (ward_fill >= DEPTH) begin
        w.rejected_flag = 1'b1;
        rejects_seen++;
      end else begin
        case (cond)
          COND_CRITICAL: level = PRIO_CRITICAL;
          COND_URGENT:   level = PRIO_URGENT;
          default:       level = PRIO_NORMAL;
        endcase
        pos = 0;
        while (pos < ward_fill && ward[pos].prio <= level) pos++;
        for (i = ward_fill; i > pos; i--) ward[i] = ward[i-1];
        ward[pos].tag  = tag;
        ward[pos].age  = age;
        ward[pos].prio = level;
        ward_fill++;
        if (ward_fill == DEPTH) full_seen++;
      end
    end else begin
      if (ward_fill == 0) begin
        w.empty_flag = 1'b1;
        empty_seen++;
      end else begin
        w.popped_valid    = 1'b1;
        w.popped_tag      = ward[0].tag;
        w.popped_age      = ward[0].age;
        w.popped_priority = ward[0].prio;
        for (i = 1; i < ward_fill; i++) ward[i-1] = ward[i];
        ward_fill--;
        pops_seen++;
      end
    end
    w.entry_count = CNT_W'(ward_fill);
    w.front_valid = (ward_fill > 0);
    w.front_tag   = (ward_fill > 0) ? ward[0].tag : '0;
    due_words.push_back(w);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ward_fill = 0;
      due_words.delete();
    end else begin
      // results first: a word accepted now can never belong to an item accepted now
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          oldest = due_words[0];
          due_words.delete(0);
          check_field("popped_valid", out_popped_valid, oldest.popped_valid);
          check_field("popped_tag", out_popped_tag, oldest.popped_tag);
          check_field("popped_age", out_popped_age, oldest.popped_age);
          check_field("popped_priority", out_popped_priority, oldest.popped_priority);
          check_field("empty_flag", out_empty_flag, oldest.empty_flag);
          check_field("rejected_flag", out_rejected_flag, oldest.rejected_flag);
          check_field("entry_count", out_entry_count, oldest.entry_count);
          check_field("front_valid", out_front_valid, oldest.front_valid);
          check_field("front_tag", out_front_tag, oldest.front_tag);
        end
        words_seen++;
      end
      if (in_valid && !in_stall) begin
        triage_step(opcode_t'(in_opcode), in_entry_tag, in_entry_age, in_condition_code);
      end
    end
    pending = due_words.size();
  end

endmodule
`default_nettype wire

[tb/tb_top.sv]
// testbench top for the stable priority queue: clock, reset, stimulus and verdict
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 16;
  localparam int TAG_BITS     = 16;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 800;
  localparam int QUIET_ITEMS  = 100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_LIMIT  = 5000;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  wire logic                     in_stall;
  logic                          in_opcode;
  logic [TAG_BITS-1:0]           in_entry_tag;
  logic [spq_pkg::AGE_W-1:0]     in_entry_age;
  logic [spq_pkg::COND_W-1:0]    in_condition_code;
  wire logic                     out_valid;
  logic                          out_stall;
  wire logic                     out_popped_valid;
  wire logic [TAG_BITS-1:0]      out_popped_tag;
  wire logic [spq_pkg::AGE_W-1:0]  out_popped_age;
  wire logic [spq_pkg::PRIO_W-1:0] out_popped_priority;
  wire logic                     out_empty_flag;
  wire logic                     out_rejected_flag;
  wire logic [CNT_W-1:0]         out_entry_count;
  wire logic                     out_front_valid;
  wire logic [TAG_BITS-1:0]      out_front_tag;

  int fail_count;
  int pending;
  int words_seen;
  int pops_seen;
  int empty_seen;
  int rejects_seen;
  int full_seen;
  int cycle_count;

  bit quiet;
  bit idle_enable;
  bit stall_enable;

  stable_priority_queue_core #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_entry_tag        (in_entry_tag),
    .in_entry_age        (in_entry_age),
    .in_condition_code   (in_condition_code),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_popped_valid    (out_popped_valid),
    .out_popped_tag      (out_popped_tag),
    .out_popped_age      (out_popped_age),
    .out_popped_priority (out_popped_priority),
    .out_empty_flag      (out_empty_flag),
    .out_rejected_flag   (out_rejected_flag),
    .out_entry_count     (out_entry_count),
    .out_front_valid     (out_front_valid),
    .out_front_tag       (out_front_tag)
  );

  spq_checker #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS),
    .CNT_W    (CNT_W)
  ) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_entry_tag        (in_entry_tag),
    .in_entry_age        (in_entry_age),
    .in_condition_code   (in_condition_code),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_popped_valid    (out_popped_valid),
    .out_popped_tag      (out_popped_tag),
    .out_popped_age      (out_popped_age),
    .out_popped_priority (out_popped_priority),
    .out_empty_flag      (out_empty_flag),
    .out_rejected_flag   (out_rejected_flag),
    .out_entry_count     (out_entry_count),
    .out_front_valid     (out_front_valid),
    .out_front_tag       (out_front_tag),
    .fail_count          (fail_count),
    .pending             (pending),
    .words_seen          (words_seen),
    .pops_seen           (pops_seen),
    .empty_seen          (empty_seen),
    .rejects_seen        (rejects_seen),
    .full_seen           (full_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("stable_priority_queue_core regression: fail");
      $finish;
    end
  end

  // random stall bursts on the result side
  initial begin
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet && stall_enable) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(input spq_pkg::opcode_t op, input logic [TAG_BITS-1:0] tag,
                           input logic [spq_pkg::AGE_W-1:0] age,
                           input logic [spq_pkg::COND_W-1:0] cond);
    if (!quiet && idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_entry_tag      <= tag;
    in_entry_age      <= age;
    in_condition_code <= cond;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    int   sent;
    int   seg_len;
    int   k;
    int   add_pct;
    int   drain_cycles;
    mix_t mix;
    spq_pkg::opcode_t op;
    logic [TAG_BITS-1:0] tag;
    logic [spq_pkg::AGE_W-1:0] age;

    quiet             = 1'b0;
    idle_enable       = 1'b1;
    stall_enable      = 1'b1;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_opcode         <= spq_pkg::OP_ADD;
    in_entry_tag      <= '0;
    in_entry_age      <= '0;
    in_condition_code <= spq_pkg::COND_CRITICAL;
    out_stall         <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty pop, every condition code, field extremes, stable order, full queue
    send_word(spq_pkg::OP_PROC, 16'hFFFF, 8'hFF, 2'd3);
    send_word(spq_pkg::OP_ADD, 16'h0000, 8'h00, spq_pkg::COND_CRITICAL);
    send_word(spq_pkg::OP_ADD, 16'hFFFF, 8'hFF, spq_pkg::COND_URGENT);
    send_word(spq_pkg::OP_ADD, 16'h1234, 8'h7F, 2'd2);
    send_word(spq_pkg::OP_ADD, 16'hABCD, 8'h80, 2'd3);
    send_word(spq_pkg::OP_ADD, 16'h5555, 8'h01, spq_pkg::COND_CRITICAL);
    send_word(spq_pkg::OP_PROC, 16'h0000, 8'h00, spq_pkg::COND_CRITICAL);
    send_word(spq_pkg::OP_PROC, 16'h0000, 8'h00, spq_pkg::COND_CRITICAL);
    for (k = 0; k < 13; k++) begin
      send_word(spq_pkg::OP_ADD, 16'($urandom), 8'($urandom), 2'(k % 4));
    end
    send_word(spq_pkg::OP_ADD, 16'hFFFF, 8'hFF, spq_pkg::COND_CRITICAL);
    send_word(spq_pkg::OP_PROC, 16'hFFFF, 8'hFF, 2'd3);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      seg_len      = $urandom_range(8, 60);
      mix          = mix_t'($urandom_range(0, 2));
      idle_enable  = ($urandom_range(0, 3) != 0);
      stall_enable = ($urandom_range(0, 3) != 0);
      case (mix)
        MIX_FILL:  add_pct = 85;
        MIX_DRAIN: add_pct = 15;
        default:   add_pct = 50;
      endcase
      for (k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
        if (sent >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
        op  = ($urandom_range(0, 99) < add_pct) ? spq_pkg::OP_ADD : spq_pkg::OP_PROC;
        tag = ($urandom_range(0, 15) == 0) ? {TAG_BITS{1'b1}} : TAG_BITS'($urandom);
        age = ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom);
        send_word(op, tag, age, 2'($urandom_range(0, 3)));
        sent++;
      end
    end
    in_valid <= 1'b0;

    drain_cycles = 0;
    @(negedge clk);
    while (pending != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_cycles++;
    end
    if (pending != 0) begin
      $display("stable_priority_queue_core regression: fail");
      $finish;
    end else begin
      repeat (10) @(negedge clk);
      $display("checked %0d result words: %0d pops, %0d pops of an empty queue,",
               words_seen, pops_seen, empty_seen);
      $display("%0d adds refused on a full queue, queue filled to capacity %0d times",
               rejects_seen, full_seen);
      if (fail_count == 0 && pending == 0) begin
        $display("stable_priority_queue_core regression: pass");
      end else begin
        $display("stable_priority_queue_core regression: fail");
      end
      $finish;
    end
  end

endmodule
`default_nettype wire
